FILE: design/bdq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
package bdq_pkg;

   // Number of words the queue can hold.
   localparam int CAPACITY = 16;
   // Width of an element count from zero up to CAPACITY.
   localparam int OCC_W = $clog2(CAPACITY + 1);

   typedef logic signed [31:0] word_type;

   // Request kinds.
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_DUMP       = 3'd4;

   // Response status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Operation broadcast to every storage cell in a cycle.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_R,
      CELL_SHIFT_L,
      CELL_PUSH_BACK,
      CELL_POP_BACK,
      CELL_ROT_L,
      CELL_ROT_R
   } cell_op_type;

   // Control bundle from the sequencer to the cell row.
   typedef struct packed {
      cell_op_type op;
      word_type    word;
   } cell_ctrl_type;

endpackage

FILE: design/bdq_cell.sv
// One storage cell of the queue row: a word and its occupied flag.
module bdq_cell import bdq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          left_valid,
   input  word_type      left_data,
   input  logic          right_valid,
   input  word_type      right_data,
   output logic          valid,
   output word_type      data
);

   logic     valid_ff;
   logic     valid_in;
   word_type data_ff;
   word_type data_in;

   // Next cell contents for the broadcast operation.
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (ctrl.op)
         CELL_SHIFT_R: begin
            valid_in = left_valid;
            data_in  = left_data;
         end
         CELL_SHIFT_L: begin
            valid_in = right_valid;
            data_in  = right_data;
         end
         CELL_PUSH_BACK: begin
            // The first empty cell after the occupied run takes the word.
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               data_in  = ctrl.word;
            end
         end
         CELL_POP_BACK: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         CELL_ROT_L: begin
            // The back cell wraps around to the head word.
            if (valid_ff) begin
               data_in = right_valid ? right_data : ctrl.word;
            end
         end
         CELL_ROT_R: begin
            if (valid_ff) begin
               data_in = left_data;
            end
         end
         default: begin
         end
      endcase
   end

   // Occupied flag is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

FILE: design/bounded_deque.sv
// Top level of the bounded double-ended queue: sequencer, cell row, response register.
//
//  Channel  Direction  tdata          tuser                       tlast
//  req_     in         value[31:0]    kind[2:0]                   -
//  rsp_     out        data[31:0]     status[1:0], backward[2]    last
//
// A push or pop request gives one response.
// A dump of n words holds off requests while the cell row rotates left n times
// to show the words front to back, then right n times to show them back to front.
// Reset is synchronous; it empties the queue. Stored words are not cleared.
// A stalled response holds the row and blocks new requests until it is taken.
module bounded_deque import bdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] data
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] backward
   output logic        rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FWD  = 2'd1;
   localparam logic [1:0] ST_BWD  = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [OCC_W-1:0] remain_ff, remain_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   word_type       rsp_data_ff, rsp_data_in;
   logic           rsp_backward_ff, rsp_backward_in;
   logic           rsp_last_ff, rsp_last_in;

   cell_ctrl_type  ctrl;
   logic [CAPACITY-1:0] cell_valid;
   logic [CAPACITY-1:0] last_mask;
   word_type       cell_data [CAPACITY];
   word_type       head_data;
   word_type       tail_data;
   word_type       req_value;
   logic           out_free;
   logic           req_accept;
   logic           is_full;
   logic           is_empty;

   assign req_value  = word_type'(req_tdata);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign is_full    = cell_valid[CAPACITY-1];
   assign is_empty   = !cell_valid[0];

   // Front word sits in the first cell; the back word is the last occupied one.
   assign head_data = cell_data[0];
   assign last_mask = cell_valid & ~(cell_valid >> 1);

   always_comb begin
      tail_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_data = tail_data | (last_mask[i] ? cell_data[i] : word_type'(0));
      end
   end

   // Row of storage cells, each linked to its neighbors; the first cell takes the control word from its left.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic     left_valid;
      word_type left_data;
      logic     right_valid;
      word_type right_data;

      if (i == 0) begin : g_first
         assign left_valid = 1'b1;
         assign left_data  = ctrl.word;
      end else begin : g_mid_left
         assign left_valid = cell_valid[i-1];
         assign left_data  = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_valid = 1'b0;
         assign right_data  = '0;
      end else begin : g_mid_right
         assign right_valid = cell_valid[i+1];
         assign right_data  = cell_data[i+1];
      end

      bdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_valid  (left_valid),
         .left_data   (left_data),
         .right_valid (right_valid),
         .right_data  (right_data),
         .valid       (cell_valid[i]),
         .data        (cell_data[i])
      );
   end

   // Sequencer: decodes requests and steps through the two dump passes.
   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      remain_in       = remain_ff;
      ctrl.op         = CELL_HOLD;
      ctrl.word       = req_value;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_backward_in = rsp_backward_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_status_in   = STATUS_OK;
               rsp_data_in     = '0;
               rsp_backward_in = 1'b0;
               rsp_last_in     = 1'b1;
               unique case (req_tuser) inside
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctrl.op = (req_tuser == KIND_PUSH_FRONT) ? CELL_SHIFT_R
                                                                 : CELL_PUSH_BACK;
                        occ_in  = occ_ff + OCC_W'(1);
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (req_tuser == KIND_POP_FRONT) begin
                        ctrl.op     = CELL_SHIFT_L;
                        rsp_data_in = head_data;
                        occ_in      = occ_ff - OCC_W'(1);
                     end else begin
                        ctrl.op     = CELL_POP_BACK;
                        rsp_data_in = tail_data;
                        occ_in      = occ_ff - OCC_W'(1);
                     end
                  end
                  KIND_DUMP: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in  = ST_FWD;
                        remain_in = occ_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FWD: begin
            // Show the front word, then rotate the row one step left.
            if (out_free) begin
               ctrl.op         = CELL_ROT_L;
               ctrl.word       = head_data;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = STATUS_OK;
               rsp_data_in     = head_data;
               rsp_backward_in = 1'b0;
               rsp_last_in     = 1'b0;
               if (remain_ff == OCC_W'(1)) begin
                  state_in  = ST_BWD;
                  remain_in = occ_ff;
               end else begin
                  remain_in = remain_ff - OCC_W'(1);
               end
            end
         end
         ST_BWD: begin
            // Show the back word, then rotate the row one step right.
            if (out_free) begin
               ctrl.op         = CELL_ROT_R;
               ctrl.word       = tail_data;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = STATUS_OK;
               rsp_data_in     = tail_data;
               rsp_backward_in = 1'b1;
               rsp_last_in     = (remain_ff == OCC_W'(1));
               if (remain_ff == OCC_W'(1)) begin
                  state_in = ST_IDLE;
               end
               remain_in = remain_ff - OCC_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_backward_ff <= rsp_backward_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_backward_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The element count always matches the number of occupied cells.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_W'($countones(cell_valid)))
      else $error("element count disagrees with occupied cells");

   // Occupied cells always form one run starting at the first cell.
   assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
      else $error("occupied cells are not contiguous from the front");

   // A push into a full queue is answered with the full status.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && is_full &&
      (req_tuser == KIND_PUSH_FRONT || req_tuser == KIND_PUSH_BACK)
      |=> rsp_tvalid && rsp_tuser[1:0] == STATUS_FULL && rsp_tlast)
      else $error("push into full queue not flagged");

   // The back-to-front pass ends the dump with the last flag on its final word.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BWD && out_free && remain_ff == OCC_W'(1)
      |=> rsp_tvalid && rsp_tlast && rsp_tuser[2] && state_ff == ST_IDLE)
      else $error("dump did not end with a marked backward word");

endmodule
